// ----- hdl/oate_pkg.sv -----
// ----------------------------------------------------------------------------
// Ordered array table engine package
// Shared types and fixed field widths for the controller and the datapath.
// ----------------------------------------------------------------------------
package oate_pkg;

  localparam int MODE_W = 3;
  localparam int POS_W  = 7;
  localparam int END_W  = 6;
  localparam int DATA_W = 32;
  localparam int FILL_W = 7;

  typedef enum logic [MODE_W-1:0] {
    MODE_APPEND = 3'd0,
    MODE_INSERT = 3'd1,
    MODE_MODIFY = 3'd2,
    MODE_DELETE = 3'd3,
    MODE_READ   = 3'd4,
    MODE_COUNT  = 3'd5
  } mode_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_RD_OLD,
    S_DEL_SHIFT,
    S_INS_SHIFT,
    S_INS_WR,
    S_CNT_KEY,
    S_CNT_CMP,
    S_DONE
  } state_t;

  // Memory read address select.
  typedef enum logic [2:0] {
    RD_NONE,
    RD_POS,
    RD_TAIL,
    RD_J_DEC,
    RD_J_INC,
    RD_K,
    RD_K_INC
  } rd_sel_t;

  // Memory write select.
  typedef enum logic [2:0] {
    WR_NONE,
    WR_TAIL,
    WR_POS,
    WR_UP,
    WR_DOWN
  } wr_sel_t;

  typedef enum logic [2:0] {
    J_HOLD,
    J_POS,
    J_TAIL,
    J_DEC,
    J_INC
  } j_op_t;

  typedef enum logic [1:0] {
    K_HOLD,
    K_POS,
    K_INC
  } k_op_t;

  typedef enum logic [1:0] {
    N_HOLD,
    N_INC,
    N_DEC
  } n_op_t;

  typedef enum logic [1:0] {
    C_HOLD,
    C_CLEAR,
    C_INC
  } cnt_op_t;

  typedef enum logic [2:0] {
    RES_HOLD,
    RES_ZERO,
    RES_ELEM,
    RES_COUNT,
    RES_ERROR
  } res_op_t;

  typedef struct packed {
    logic    req_load;
    rd_sel_t rd_sel;
    wr_sel_t wr_sel;
    j_op_t   j_op;
    k_op_t   k_op;
    n_op_t   n_op;
    cnt_op_t cnt_op;
    logic    key_load;
    res_op_t res_op;
  } oate_cmd_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              req_err;
    logic              pos_eq_n;
    logic              j_eq_pos;
    logic              j_eq_last;
    logic              j_inc_lt_n;
    logic              k_eq_j;
    logic              k_inc_eq_j;
    logic              match;
  } oate_stat_t;

endpackage

// ----- hdl/ordered_array_table_engine.sv -----
// ----------------------------------------------------------------------------
// Ordered array table engine
// Bounded ordered array with append, insert, modify, delete, read and a
// distinct-value count over a position range.
// ----------------------------------------------------------------------------
// A request word is taken at a rising edge with start high and busy low.
// Its fields are in_mode, in_position, in_value and in_range_end. Every
// request gives exactly one result word, shown for one cycle with out_valid
// high: out_data, out_fill_count (count after the request) and out_error.
// The receiver cannot hold a result off, so nothing ever waits on it.
// Append, refused requests and an insert at the end finish soonest; read
// and modify add a read state. Delete at p shifts the n - 1 - p elements
// above p down one place, and insert at p shifts the n - p elements from p
// up. A distinct count over a range compares each element with the earlier
// ones in the range, and stops that scan early at a duplicate. The element
// memory has a single read and a single write port, and one element is
// moved or compared per cycle.
// A new request is taken in the cycle that shows the previous result.
// Reset clears the fill count and the controller; the element memory is not
// cleared, since no entry at or above the fill count is ever read.
// ----------------------------------------------------------------------------
module ordered_array_table_engine
  import oate_pkg::*;
#(
  parameter int CAPACITY   = 64,
  parameter int ELEM_WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [MODE_W-1:0]        in_mode,
  input  logic [POS_W-1:0]         in_position,
  input  logic signed [DATA_W-1:0] in_value,
  input  logic [END_W-1:0]         in_range_end,
  output logic                     out_valid,
  output logic signed [DATA_W-1:0] out_data,
  output logic [FILL_W-1:0]        out_fill_count,
  output logic                     out_error
);

  // The controller drives the datapath only through these two structs.
  oate_cmd_t  cmd;
  oate_stat_t stat;

  oate_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .stat      (stat),
    .cmd       (cmd)
  );

  // The datapath holds the element memory and the fill count, and it
  // registers the result word, which holds until a later request sets it anew.
  oate_dp #(
    .CAPACITY   (CAPACITY),
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mode        (in_mode),
    .in_position    (in_position),
    .in_value       (in_value),
    .in_range_end   (in_range_end),
    .cmd            (cmd),
    .stat           (stat),
    .out_data       (out_data),
    .out_fill_count (out_fill_count),
    .out_error      (out_error)
  );

endmodule

// ----- hdl/oate_ctrl.sv -----
// ----------------------------------------------------------------------------
// Ordered array table engine controller
// Sequences each request over the datapath: checks, shifts and range scans.
// ----------------------------------------------------------------------------
module oate_ctrl
  import oate_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  output logic       out_valid,
  input  oate_stat_t stat,
  output oate_cmd_t  cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    cmd.rd_sel   = RD_NONE;
    cmd.wr_sel   = WR_NONE;
    cmd.j_op     = J_HOLD;
    cmd.k_op     = K_HOLD;
    cmd.n_op     = N_HOLD;
    cmd.cnt_op   = C_HOLD;
    cmd.res_op   = RES_HOLD;
    busy         = 1'b1;
    out_valid    = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.req_load = 1'b1;
          state_nxt    = S_CHECK;
        end
      end

      S_CHECK: begin
        if (stat.req_err) begin
          cmd.res_op = RES_ERROR;
          state_nxt  = S_DONE;
        end else begin
          unique case (stat.mode)
            MODE_APPEND: begin
              cmd.wr_sel = WR_TAIL;
              cmd.n_op   = N_INC;
              cmd.res_op = RES_ZERO;
              state_nxt  = S_DONE;
            end
            MODE_INSERT: begin
              cmd.res_op = RES_ZERO;
              if (stat.pos_eq_n) begin
                cmd.wr_sel = WR_POS;
                cmd.n_op   = N_INC;
                state_nxt  = S_DONE;
              end else begin
                cmd.rd_sel = RD_TAIL;
                cmd.j_op   = J_TAIL;
                state_nxt  = S_INS_SHIFT;
              end
            end
            MODE_MODIFY: begin
              // The read port returns the old word while the new one is written.
              cmd.rd_sel = RD_POS;
              cmd.wr_sel = WR_POS;
              state_nxt  = S_RD_OLD;
            end
            MODE_DELETE, MODE_READ: begin
              cmd.rd_sel = RD_POS;
              cmd.j_op   = J_POS;
              state_nxt  = S_RD_OLD;
            end
            MODE_COUNT: begin
              cmd.rd_sel = RD_POS;
              cmd.j_op   = J_POS;
              cmd.k_op   = K_POS;
              cmd.cnt_op = C_CLEAR;
              state_nxt  = S_CNT_KEY;
            end
            default: begin
              cmd.res_op = RES_ERROR;
              state_nxt  = S_DONE;
            end
          endcase
        end
      end

      S_RD_OLD: begin
        cmd.res_op = RES_ELEM;
        state_nxt  = S_DONE;
        if (stat.mode == MODE_DELETE) begin
          if (stat.j_inc_lt_n) begin
            cmd.rd_sel = RD_J_INC;
            cmd.j_op   = J_INC;
            state_nxt  = S_DEL_SHIFT;
          end else begin
            cmd.n_op = N_DEC;
          end
        end
      end

      S_DEL_SHIFT: begin
        cmd.wr_sel = WR_DOWN;
        if (stat.j_inc_lt_n) begin
          cmd.rd_sel = RD_J_INC;
          cmd.j_op   = J_INC;
        end else begin
          cmd.n_op  = N_DEC;
          state_nxt = S_DONE;
        end
      end

      S_INS_SHIFT: begin
        cmd.wr_sel = WR_UP;
        if (stat.j_eq_pos) begin
          state_nxt = S_INS_WR;
        end else begin
          cmd.rd_sel = RD_J_DEC;
          cmd.j_op   = J_DEC;
        end
      end

      S_INS_WR: begin
        cmd.wr_sel = WR_POS;
        cmd.n_op   = N_INC;
        state_nxt  = S_DONE;
      end

      S_CNT_KEY: begin
        cmd.key_load = 1'b1;
        if (stat.k_eq_j) begin
          // Nothing earlier in the range to compare against: a new value.
          cmd.cnt_op = C_INC;
          if (stat.j_eq_last) begin
            cmd.res_op = RES_COUNT;
            state_nxt  = S_DONE;
          end else begin
            cmd.rd_sel = RD_J_INC;
            cmd.j_op   = J_INC;
            cmd.k_op   = K_POS;
          end
        end else begin
          cmd.rd_sel = RD_K;
          state_nxt  = S_CNT_CMP;
        end
      end

      S_CNT_CMP: begin
        if (stat.match || stat.k_inc_eq_j) begin
          if (!stat.match) begin
            cmd.cnt_op = C_INC;
          end
          if (stat.j_eq_last) begin
            cmd.res_op = RES_COUNT;
            state_nxt  = S_DONE;
          end else begin
            cmd.rd_sel = RD_J_INC;
            cmd.j_op   = J_INC;
            cmd.k_op   = K_POS;
            state_nxt  = S_CNT_KEY;
          end
        end else begin
          cmd.rd_sel = RD_K_INC;
          cmd.k_op   = K_INC;
        end
      end

      S_DONE: begin
        busy      = 1'b0;
        out_valid = 1'b1;
        if (start) begin
          cmd.req_load = 1'b1;
          state_nxt    = S_CHECK;
        end else begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ----- hdl/oate_dp.sv -----
// ----------------------------------------------------------------------------
// Ordered array table engine datapath
// Element memory, fill count, scan indexes, distinct counter and result.
// ----------------------------------------------------------------------------
module oate_dp
  import oate_pkg::*;
#(
  parameter int CAPACITY   = 64,
  parameter int ELEM_WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [MODE_W-1:0]        in_mode,
  input  logic [POS_W-1:0]         in_position,
  input  logic signed [DATA_W-1:0] in_value,
  input  logic [END_W-1:0]         in_range_end,
  input  oate_cmd_t                cmd,
  output oate_stat_t               stat,
  output logic signed [DATA_W-1:0] out_data,
  output logic [FILL_W-1:0]        out_fill_count,
  output logic                     out_error
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = (CW > POS_W) ? CW : POS_W;

  logic [ELEM_WIDTH-1:0]  mem [CAPACITY];

  logic [MODE_W-1:0]      mode_r;
  logic [POS_W-1:0]       pos_r;
  logic [ELEM_WIDTH-1:0]  val_r;
  logic [END_W-1:0]       last_r;
  logic [CW-1:0]          n_r, n_nxt;
  logic [AW-1:0]          j_r, j_nxt;
  logic [AW-1:0]          k_r, k_nxt;
  logic [CW-1:0]          cnt_r, cnt_nxt;
  logic [ELEM_WIDTH-1:0]  key_r;
  logic [ELEM_WIDTH-1:0]  rdata_r;
  logic signed [DATA_W-1:0] res_r, res_nxt;
  logic                   err_r, err_nxt;

  logic                   rd_en, wr_en;
  logic [AW-1:0]          rd_addr, wr_addr;
  logic [ELEM_WIDTH-1:0]  wr_data;

  logic [IW-1:0]          n_ext, pos_ext, last_ext, j_ext;
  logic [AW-1:0]          pos_a, tail_a;
  logic                   full;

  assign n_ext    = IW'(n_r);
  assign pos_ext  = IW'(pos_r);
  assign last_ext = IW'(last_r);
  assign j_ext    = IW'(j_r);
  assign pos_a    = AW'(pos_r);
  assign tail_a   = AW'(n_r - CW'(1));
  assign full     = (n_r == CW'(CAPACITY));

  // Request checks against the current fill count.
  always_comb begin
    stat.mode = mode_r;
    case (mode_r)
      MODE_APPEND:                          stat.req_err = full;
      MODE_INSERT:                          stat.req_err = (pos_ext > n_ext) || full;
      MODE_MODIFY, MODE_DELETE, MODE_READ:  stat.req_err = (pos_ext >= n_ext);
      MODE_COUNT:   stat.req_err = (pos_ext > last_ext) || (last_ext >= n_ext);
      default:                              stat.req_err = 1'b1;
    endcase
    stat.pos_eq_n   = (pos_ext == n_ext);
    stat.j_eq_pos   = (j_ext == pos_ext);
    stat.j_eq_last  = (j_ext == last_ext);
    stat.j_inc_lt_n = ((j_ext + IW'(1)) < n_ext);
    stat.k_eq_j     = (k_r == j_r);
    stat.k_inc_eq_j = (AW'(k_r + AW'(1)) == j_r);
    stat.match      = (rdata_r == key_r);
  end

  // Memory address and data selection.
  always_comb begin
    rd_en   = 1'b1;
    rd_addr = pos_a;
    case (cmd.rd_sel)
      RD_POS:   rd_addr = pos_a;
      RD_TAIL:  rd_addr = tail_a;
      RD_J_DEC: rd_addr = AW'(j_r - AW'(1));
      RD_J_INC: rd_addr = AW'(j_r + AW'(1));
      RD_K:     rd_addr = k_r;
      RD_K_INC: rd_addr = AW'(k_r + AW'(1));
      default:  rd_en   = 1'b0;
    endcase

    wr_en   = 1'b1;
    wr_addr = pos_a;
    wr_data = val_r;
    case (cmd.wr_sel)
      WR_TAIL: wr_addr = AW'(n_r);
      WR_POS:  wr_addr = pos_a;
      WR_UP: begin
        wr_addr = AW'(j_r + AW'(1));
        wr_data = rdata_r;
      end
      WR_DOWN: begin
        wr_addr = AW'(j_r - AW'(1));
        wr_data = rdata_r;
      end
      default: wr_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  // Index, counter and result next values.
  always_comb begin
    case (cmd.n_op)
      N_INC:   n_nxt = CW'(n_r + CW'(1));
      N_DEC:   n_nxt = CW'(n_r - CW'(1));
      default: n_nxt = n_r;
    endcase

    case (cmd.j_op)
      J_POS:   j_nxt = pos_a;
      J_TAIL:  j_nxt = tail_a;
      J_DEC:   j_nxt = AW'(j_r - AW'(1));
      J_INC:   j_nxt = AW'(j_r + AW'(1));
      default: j_nxt = j_r;
    endcase

    case (cmd.k_op)
      K_POS:   k_nxt = pos_a;
      K_INC:   k_nxt = AW'(k_r + AW'(1));
      default: k_nxt = k_r;
    endcase

    case (cmd.cnt_op)
      C_CLEAR: cnt_nxt = '0;
      C_INC:   cnt_nxt = CW'(cnt_r + CW'(1));
      default: cnt_nxt = cnt_r;
    endcase

    res_nxt = res_r;
    err_nxt = err_r;
    case (cmd.res_op)
      RES_ZERO: begin
        res_nxt = '0;
        err_nxt = 1'b0;
      end
      RES_ELEM: begin
        res_nxt = DATA_W'(signed'(rdata_r));
        err_nxt = 1'b0;
      end
      RES_COUNT: begin
        res_nxt = signed'(DATA_W'(cnt_nxt));
        err_nxt = 1'b0;
      end
      RES_ERROR: begin
        res_nxt = '1;
        err_nxt = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r <= '0;
    end else begin
      n_r <= n_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.req_load) begin
      mode_r <= in_mode;
      pos_r  <= in_position;
      val_r  <= ELEM_WIDTH'(in_value);
      last_r <= in_range_end;
    end
    if (cmd.key_load) begin
      key_r <= rdata_r;
    end
    j_r   <= j_nxt;
    k_r   <= k_nxt;
    cnt_r <= cnt_nxt;
    res_r <= res_nxt;
    err_r <= err_nxt;
  end

  assign out_data       = res_r;
  assign out_fill_count = FILL_W'(n_r);
  assign out_error      = err_r;

endmodule
